@@ rtl/r2fft_pkg.sv @@
package r2fft_pkg;

   // Frame geometry and number formats.
   localparam int POINTS   = 2048;
   localparam int LOG_N    = $clog2(POINTS);
   localparam int ADDR_W   = LOG_N;
   localparam int HALF_N   = POINTS / 2;
   localparam int TW_IDX_W = (LOG_N > 1) ? LOG_N - 1 : 1;
   localparam int STAGE_W  = $clog2(LOG_N + 1);
   localparam int TW_BITS  = 18;
   localparam int FRAC     = TW_BITS - 1;
   localparam int DATA_W   = 36;
   localparam int SAMPLE_W = 24;

   // Request codes.
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_RUN  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   // Result kinds.
   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_BIN  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_OUT,
      ST_REV,
      ST_REV_WA,
      ST_REV_WB,
      ST_BF_RD,
      ST_BF_MUL,
      ST_BF_SUM,
      ST_BF_ADD,
      ST_BF_WP,
      ST_BF_WQ,
      ST_DONE
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                rd_en;
      logic [ADDR_W-1:0]   addr_a;
      logic [ADDR_W-1:0]   addr_b;
      logic [TW_IDX_W-1:0] tw_idx;
      logic                tw_trivial;
      logic                mul_en;
      logic                sum_en;
      logic                add_en;
      logic                wr_p;
      logic                wr_q;
      logic                swap;
      logic                load_en;
      logic                out_bin;
   } fft_cmd_type;

   typedef logic [2*TW_BITS-1:0] tw_word_type;
   typedef tw_word_type tw_rom_type [HALF_N];

   // Bit reversal of a frame address.
   function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] v);
      logic [ADDR_W-1:0] r;
      for (int b = 0; b < ADDR_W; b++) begin
         r[b] = v[ADDR_W-1-b];
      end
      return r;
   endfunction

   // Q62 product of two non-negative Q62 values.
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] pr;
      pr = {64'd0, a} * {64'd0, b};
      return pr[125:62];
   endfunction

   // Rounded Q1.FRAC magnitude of a Q62 value, capped at the largest code.
   function automatic logic [63:0] to_tw(input logic [63:0] v);
      logic [63:0] m;
      logic [63:0] top;
      m   = (v + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
      top = (64'd1 << FRAC) - 64'd1;
      return (m > top) ? top : m;
   endfunction

   // Series sine and cosine table, evaluated at elaboration.
   function automatic tw_rom_type build_tw();
      tw_rom_type  rom;
      logic [63:0] r, u, x, x2, ts, tc, ss, sc, cm, sm, re, im;
      logic [1:0]  quad;
      for (int k = 0; k < HALF_N; k++) begin
         r    = (64'(k) << (32 - LOG_N)) & 64'hFFFF_FFFF;
         quad = r[31:30];
         u    = {34'd0, r[29:0]};
         if (u <= (64'd1 << 29)) begin
            x = u * 64'd6746518852;
         end else begin
            x = ((64'd1 << 30) - u) * 64'd6746518852;
         end
         x2 = mul_q62(x, x);
         ts = x;
         tc = 64'd1 << 62;
         ss = x;
         sc = 64'd1 << 62;
         for (int i = 1; i <= 12; i++) begin
            ts = mul_q62(ts, x2) / 64'((2 * i) * (2 * i + 1));
            tc = mul_q62(tc, x2) / 64'((2 * i - 1) * (2 * i));
            if (i % 2 == 1) begin
               ss = ss - ts;
               sc = sc - tc;
            end else begin
               ss = ss + ts;
               sc = sc + tc;
            end
         end
         if (u <= (64'd1 << 29)) begin
            cm = to_tw(sc);
            sm = to_tw(ss);
         end else begin
            cm = to_tw(ss);
            sm = to_tw(sc);
         end
         case (quad)
            2'd0: begin re = cm;  im = sm;  end
            2'd1: begin re = -sm; im = cm;  end
            2'd2: begin re = -cm; im = -sm; end
            default: begin re = sm; im = -cm; end
         endcase
         rom[k] = {re[TW_BITS-1:0], im[TW_BITS-1:0]};
      end
      return rom;
   endfunction

   localparam tw_rom_type TW_ROM = build_tw();

endpackage

@@ rtl/r2fft_ctrl.sv @@
module r2fft_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [1:0]                  req_type,
   input  logic [r2fft_pkg::ADDR_W-1:0] req_index,
   output logic                        busy,
   output logic                        rsp_valid,
   output logic                        rsp_result_kind,
   output r2fft_pkg::fft_cmd_type      cmd
);
   import r2fft_pkg::*;

   ctrl_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]   cnt_ff, cnt_in;
   logic [STAGE_W-1:0]  stage_ff, stage_in;
   logic [ADDR_W-1:0]   rev, bx, mask, p_addr, q_addr;
   logic [TW_IDX_W-1:0] k_idx;
   logic                swap, last_cnt, last_b, last_stage, accept;

   // Address generation for the reorder pass and the butterflies.
   always_comb begin
      rev        = bit_rev(cnt_ff);
      swap       = rev > cnt_ff;
      last_cnt   = &cnt_ff;
      last_b     = (LOG_N > 1) ? &cnt_ff[TW_IDX_W-1:0] : 1'b1;
      last_stage = stage_ff == STAGE_W'(LOG_N - 1);
      bx         = {1'b0, cnt_ff[ADDR_W-2:0]};
      mask       = ~({ADDR_W{1'b1}} << stage_ff);
      p_addr     = ((bx >> stage_ff) << (stage_ff + 1'b1)) | (bx & mask);
      q_addr     = p_addr | (ADDR_W'(1) << stage_ff);
      k_idx      = TW_IDX_W'((bx & mask) << (STAGE_W'(LOG_N - 1) - stage_ff));
      accept     = start && (state_ff == ST_IDLE);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_RUN:  state_in = ST_REV;
                  REQ_READ: state_in = ST_READ_OUT;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ_OUT: state_in = ST_IDLE;
         ST_REV: begin
            if (swap) begin
               state_in = ST_REV_WA;
            end else if (last_cnt) begin
               state_in = ST_BF_RD;
            end
         end
         ST_REV_WA: state_in = ST_REV_WB;
         ST_REV_WB: state_in = last_cnt ? ST_BF_RD : ST_REV;
         ST_BF_RD:  state_in = ST_BF_MUL;
         ST_BF_MUL: state_in = ST_BF_SUM;
         ST_BF_SUM: state_in = ST_BF_ADD;
         ST_BF_ADD: state_in = ST_BF_WP;
         ST_BF_WP:  state_in = ST_BF_WQ;
         ST_BF_WQ:  state_in = (last_b && last_stage) ? ST_DONE : ST_BF_RD;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Counter updates.
   always_comb begin
      cnt_in   = cnt_ff;
      stage_in = stage_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in   = '0;
            stage_in = '0;
         end
         ST_REV: begin
            if (!swap) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_REV_WB: cnt_in = cnt_ff + 1'b1;
         ST_BF_WQ: begin
            if (last_b) begin
               cnt_in   = '0;
               stage_in = stage_ff + 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      cmd             = '0;
      busy            = state_ff != ST_IDLE;
      rsp_valid       = 1'b0;
      rsp_result_kind = KIND_DONE;
      cmd.tw_idx      = k_idx;
      cmd.tw_trivial  = k_idx == '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.rd_en   = 1'b1;
            cmd.addr_a  = req_index;
            cmd.load_en = accept && (req_type == REQ_LOAD);
         end
         ST_READ_OUT: begin
            rsp_valid       = 1'b1;
            rsp_result_kind = KIND_BIN;
            cmd.out_bin     = 1'b1;
         end
         ST_REV, ST_REV_WA, ST_REV_WB: begin
            cmd.addr_a = cnt_ff;
            cmd.addr_b = rev;
            cmd.swap   = 1'b1;
            cmd.rd_en  = state_ff == ST_REV;
            cmd.wr_p   = state_ff == ST_REV_WA;
            cmd.wr_q   = state_ff == ST_REV_WB;
         end
         ST_BF_RD, ST_BF_MUL, ST_BF_SUM, ST_BF_ADD, ST_BF_WP, ST_BF_WQ: begin
            cmd.addr_a  = p_addr;
            cmd.addr_b  = q_addr;
            cmd.rd_en   = state_ff == ST_BF_RD;
            cmd.mul_en  = state_ff == ST_BF_MUL;
            cmd.sum_en  = state_ff == ST_BF_SUM;
            cmd.add_en  = state_ff == ST_BF_ADD;
            cmd.wr_p    = state_ff == ST_BF_WP;
            cmd.wr_q    = state_ff == ST_BF_WQ;
         end
         ST_DONE: begin
            rsp_valid       = 1'b1;
            rsp_result_kind = KIND_DONE;
         end
         default: busy = 1'b1;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         stage_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         stage_ff <= stage_in;
      end
   end

endmodule

@@ rtl/r2fft_datapath.sv @@
module r2fft_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  r2fft_pkg::fft_cmd_type             cmd,
   input  logic                               csr_we,
   input  logic                               csr_inverse,
   input  logic signed [r2fft_pkg::SAMPLE_W-1:0] req_sample_re,
   input  logic signed [r2fft_pkg::SAMPLE_W-1:0] req_sample_im,
   output logic signed [r2fft_pkg::DATA_W-1:0]   rsp_out_re,
   output logic signed [r2fft_pkg::DATA_W-1:0]   rsp_out_im
);
   import r2fft_pkg::*;

   localparam int PROD_W = DATA_W + TW_BITS;
   localparam int DOT_W  = PROD_W + 1;
   localparam int RND_W  = DOT_W - FRAC;

   logic [2*DATA_W-1:0] mem [POINTS];

   logic                      inverse_ff;
   logic [2*DATA_W-1:0]       rda_ff, rdb_ff;
   tw_word_type               tw_ff;
   logic signed [PROD_W-1:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [DATA_W-1:0]  t_re_ff, t_im_ff;
   logic signed [DATA_W-1:0]  s_re_ff, s_im_ff, d_re_ff, d_im_ff;

   logic signed [DATA_W-1:0]  a_re, a_im, b_re, b_im;
   logic signed [TW_BITS-1:0] w_re, w_im;
   logic signed [DOT_W-1:0]   dot_re, dot_im;
   logic signed [DATA_W-1:0]  s_re, s_im, d_re, d_im;
   logic                      we;
   logic [ADDR_W-1:0]         waddr;
   logic [2*DATA_W-1:0]       wdata;

   // Saturate a rounded twiddle product to the data width.
   function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [DOT_W-1:0] v);
      logic signed [DOT_W-1:0] r;
      logic signed [RND_W-1:0] q;
      r = v + (DOT_W'(1) <<< (FRAC - 1));
      q = RND_W'(r >>> FRAC);
      // Out of range when the bits above the data sign bit disagree with the sign.
      if (q[RND_W-1:DATA_W-1] != {(RND_W-DATA_W+1){q[RND_W-1]}}) begin
         return q[RND_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return DATA_W'(q);
   endfunction

   // Butterfly output: saturated in forward mode, halved with round-half-up in inverse.
   function automatic logic signed [DATA_W-1:0] bf_out(input logic signed [DATA_W:0] v,
                                                       input logic inv);
      logic signed [DATA_W+1:0] h;
      h = ({v[DATA_W], v} + (DATA_W+2)'(1)) >>> 1;
      if (inv) begin
         return DATA_W'(h);
      end else if (v[DATA_W] != v[DATA_W-1]) begin
         return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return DATA_W'(v);
   endfunction

   // Operand views.
   always_comb begin
      a_re   = rda_ff[2*DATA_W-1:DATA_W];
      a_im   = rda_ff[DATA_W-1:0];
      b_re   = rdb_ff[2*DATA_W-1:DATA_W];
      b_im   = rdb_ff[DATA_W-1:0];
      w_re   = tw_ff[2*TW_BITS-1:TW_BITS];
      w_im   = inverse_ff ? -$signed(tw_ff[TW_BITS-1:0]) : $signed(tw_ff[TW_BITS-1:0]);
      dot_re = DOT_W'(p_rr_ff) - DOT_W'(p_ii_ff);
      dot_im = DOT_W'(p_ri_ff) + DOT_W'(p_ir_ff);
      s_re   = bf_out((DATA_W+1)'(a_re) + (DATA_W+1)'(t_re_ff), inverse_ff);
      s_im   = bf_out((DATA_W+1)'(a_im) + (DATA_W+1)'(t_im_ff), inverse_ff);
      d_re   = bf_out((DATA_W+1)'(a_re) - (DATA_W+1)'(t_re_ff), inverse_ff);
      d_im   = bf_out((DATA_W+1)'(a_im) - (DATA_W+1)'(t_im_ff), inverse_ff);
   end

   // Write port selection: sample load, first and second write of a butterfly or swap.
   always_comb begin
      we    = cmd.load_en || cmd.wr_p || cmd.wr_q;
      waddr = cmd.wr_q ? cmd.addr_b : cmd.addr_a;
      if (cmd.load_en) begin
         wdata = {DATA_W'(req_sample_re), DATA_W'(req_sample_im)};
      end else if (cmd.wr_p) begin
         wdata = cmd.swap ? rdb_ff : {s_re_ff, s_im_ff};
      end else begin
         wdata = cmd.swap ? rda_ff : {d_re_ff, d_im_ff};
      end
   end

   // Frame memory and twiddle table.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rda_ff <= mem[cmd.addr_a];
         rdb_ff <= mem[cmd.addr_b];
         tw_ff  <= TW_ROM[cmd.tw_idx];
      end
   end

   // Butterfly arithmetic stages.
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         p_rr_ff <= b_re * w_re;
         p_ii_ff <= b_im * w_im;
         p_ri_ff <= b_re * w_im;
         p_ir_ff <= b_im * w_re;
      end
      if (cmd.sum_en) begin
         t_re_ff <= cmd.tw_trivial ? b_re : round_sat(dot_re);
         t_im_ff <= cmd.tw_trivial ? b_im : round_sat(dot_im);
      end
      if (cmd.add_en) begin
         s_re_ff <= s_re;
         s_im_ff <= s_im;
         d_re_ff <= d_re;
         d_im_ff <= d_im;
      end
   end

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_ff <= 1'b0;
      end else if (csr_we) begin
         inverse_ff <= csr_inverse;
      end
   end

   assign rsp_out_re = cmd.out_bin ? a_re : '0;
   assign rsp_out_im = cmd.out_bin ? a_im : '0;

endmodule

@@ rtl/radix2_fft_fixed_core.sv @@
// Channel   Handshake            Payload
// request   start / busy         req_type, req_index, req_sample_re, req_sample_im
// response  rsp_valid (strobe)   rsp_result_kind, rsp_out_re, rsp_out_im
// config    csr_valid/csr_ready  csr_inverse
//
// A load writes the frame memory on its accept; a read result is strobed in the cycle right after the accept.
// A run does a bit-reversal reorder pass, then steps each butterfly through read, multiply,
// sum, add and two writes, split by the one write port of the frame memory, then a done strobe.
// Synchronous active-high reset clears control and mode; the frame memory is not cleared.
// Results are strobed for one cycle and cannot be held off; busy holds requests off.
module radix2_fft_fixed_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_type,
   input  logic [10:0]         req_index,
   input  logic signed [23:0]  req_sample_re,
   input  logic signed [23:0]  req_sample_im,
   output logic                rsp_valid,
   output logic                rsp_result_kind,
   output logic signed [35:0]  rsp_out_re,
   output logic signed [35:0]  rsp_out_im,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_inverse
);
   import r2fft_pkg::*;

   fft_cmd_type cmd;

   // The mode register is always writable.
   assign csr_ready = 1'b1;

   r2fft_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_type        (req_type),
      .req_index       (req_index[ADDR_W-1:0]),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .cmd             (cmd)
   );

   r2fft_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_we        (csr_valid && csr_ready),
      .csr_inverse   (csr_inverse),
      .req_sample_re (req_sample_re),
      .req_sample_im (req_sample_im),
      .rsp_out_re    (rsp_out_re),
      .rsp_out_im    (rsp_out_im)
   );

endmodule

@@ verif/radix2_fft_fixed_core_tb.sv @@
`timescale 1ns / 1ps

module radix2_fft_fixed_core_tb;
   import r2fft_pkg::*;

   localparam int NPTS       = 2048;
   localparam int HALF       = NPTS / 2;
   localparam int LOGN       = 11;
   localparam int WDOG_LIMIT = 400000;
   localparam int SETTLE     = 12;
   localparam longint MAXV   = 64'sd34359738367;
   localparam longint MINV   = -64'sd34359738368;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef enum logic [1:0] {SEQ_REQ, SEQ_CSR, SEQ_DRAIN} seq_kind_type;

   typedef struct {
      seq_kind_type       kind;
      logic [1:0]         code;
      logic [10:0]        idx;
      logic signed [23:0] re;
      logic signed [23:0] im;
      logic               inv;
   } pending_item_type;

   typedef struct {
      logic               kind;
      logic signed [35:0] re;
      logic signed [35:0] im;
   } bin_result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_type;
   logic [10:0]        req_index;
   logic signed [23:0] req_sample_re;
   logic signed [23:0] req_sample_im;
   logic               rsp_valid;
   logic               rsp_result_kind;
   logic signed [35:0] rsp_out_re;
   logic signed [35:0] rsp_out_im;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_inverse;

   pending_item_type pending_q[$];
   bin_result_type   expected_q[$];

   // Predictor state: frame memory, twiddle table and mode.
   longint frame_re[NPTS];
   longint frame_im[NPTS];
   longint tw_cos[HALF];
   longint tw_sin[HALF];
   logic   inverse_mode;

   int error_count;
   int gap_left;
   int settle_count;
   int idle_cycles;

   radix2_fft_fixed_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_index(req_index),
      .req_sample_re(req_sample_re), .req_sample_im(req_sample_im),
      .rsp_valid(rsp_valid), .rsp_result_kind(rsp_result_kind),
      .rsp_out_re(rsp_out_re), .rsp_out_im(rsp_out_im),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_inverse(csr_inverse)
   );

   // Clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Fixed-point Q62 product of two non-negative values.
   function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // Rounded twiddle magnitude of a Q62 value, capped at the largest code.
   function automatic longint q62_to_twiddle(input logic [63:0] v);
      logic [63:0] m;
      m = (v + (64'd1 << 44)) >> 45;
      return (m > 64'd131071) ? 131071 : longint'(m);
   endfunction

   // Build the twiddle table with a thirteen-term Taylor series per octant.
   task automatic build_twiddles();
      logic [31:0] r;
      logic [63:0] u, x, x2, ts, tc, ss, sc;
      longint      cm, sm;
      for (int k = 0; k < HALF; k++) begin
         r = 32'(k) << (32 - LOGN);
         u = {34'd0, r[29:0]};
         x = (u <= (64'd1 << 29)) ? u * 64'd6746518852 : ((64'd1 << 30) - u) * 64'd6746518852;
         x2 = q62_product(x, x);
         ts = x;
         tc = 64'd1 << 62;
         ss = x;
         sc = 64'd1 << 62;
         for (int i = 1; i <= 12; i++) begin
            ts = q62_product(ts, x2) / 64'((2 * i) * (2 * i + 1));
            tc = q62_product(tc, x2) / 64'((2 * i - 1) * (2 * i));
            if (i % 2 == 1) begin
               ss = ss - ts;
               sc = sc - tc;
            end else begin
               ss = ss + ts;
               sc = sc + tc;
            end
         end
         if (u <= (64'd1 << 29)) begin
            cm = q62_to_twiddle(sc);
            sm = q62_to_twiddle(ss);
         end else begin
            cm = q62_to_twiddle(ss);
            sm = q62_to_twiddle(sc);
         end
         case (r[31:30])
            2'd0: begin tw_cos[k] = cm;  tw_sin[k] = sm;  end
            2'd1: begin tw_cos[k] = -sm; tw_sin[k] = cm;  end
            2'd2: begin tw_cos[k] = -cm; tw_sin[k] = -sm; end
            default: begin tw_cos[k] = sm; tw_sin[k] = -cm; end
         endcase
      end
   endtask

   function automatic longint clamp36(input longint v);
      return (v > MAXV) ? MAXV : ((v < MINV) ? MINV : v);
   endfunction

   // Exact sum of products, rounded half up at the twiddle point, then clamped.
   function automatic longint twiddle_dot(input longint p, input longint q);
      return clamp36((p + q + 64'sd65536) >>> 17);
   endfunction

   // In-place decimation-in-time transform of the predictor frame.
   task automatic transform_frame();
      int     rev, p, q, k, half_len;
      longint t, br, bi, tr, ti, ar, ai, wr, wi;
      for (int i = 0; i < NPTS; i++) begin
         rev = 0;
         for (int b = 0; b < LOGN; b++) rev = (rev << 1) | ((i >> b) & 1);
         if (rev > i) begin
            t = frame_re[i]; frame_re[i] = frame_re[rev]; frame_re[rev] = t;
            t = frame_im[i]; frame_im[i] = frame_im[rev]; frame_im[rev] = t;
         end
      end
      for (int len = 2; len <= NPTS; len = len * 2) begin
         half_len = len / 2;
         for (int base = 0; base < NPTS; base += len) begin
            for (int i = 0; i < half_len; i++) begin
               p = base + i;
               q = p + half_len;
               k = i * (NPTS / len);
               br = frame_re[q];
               bi = frame_im[q];
               if (k == 0) begin
                  tr = br;
                  ti = bi;
               end else begin
                  wr = tw_cos[k];
                  wi = inverse_mode ? -tw_sin[k] : tw_sin[k];
                  tr = twiddle_dot(br * wr, -(bi * wi));
                  ti = twiddle_dot(br * wi, bi * wr);
               end
               ar = frame_re[p];
               ai = frame_im[p];
               if (inverse_mode) begin
                  frame_re[p] = clamp36((ar + tr + 1) >>> 1);
                  frame_im[p] = clamp36((ai + ti + 1) >>> 1);
                  frame_re[q] = clamp36((ar - tr + 1) >>> 1);
                  frame_im[q] = clamp36((ai - ti + 1) >>> 1);
               end else begin
                  frame_re[p] = clamp36(ar + tr);
                  frame_im[p] = clamp36(ai + ti);
                  frame_re[q] = clamp36(ar - tr);
                  frame_im[q] = clamp36(ai - ti);
               end
            end
         end
      end
   endtask

   // Apply one accepted request item to the predictor.
   task automatic predict_request(input pending_item_type it);
      bin_result_type res;
      case (it.code)
         REQ_LOAD: begin
            frame_re[it.idx] = longint'(it.re);
            frame_im[it.idx] = longint'(it.im);
         end
         REQ_RUN: begin
            transform_frame();
            res.kind = KIND_DONE;
            res.re   = '0;
            res.im   = '0;
            expected_q.push_back(res);
         end
         REQ_READ: begin
            res.kind = KIND_BIN;
            res.re   = frame_re[it.idx][35:0];
            res.im   = frame_im[it.idx][35:0];
            expected_q.push_back(res);
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Stimulus helpers.
   function automatic logic signed [23:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic push_request(input logic [1:0] code, input int idx,
                               input logic signed [23:0] re, input logic signed [23:0] im);
      pending_item_type it;
      it.kind = SEQ_REQ;
      it.code = code;
      it.idx  = 11'(idx);
      it.re   = re;
      it.im   = im;
      it.inv  = 1'b0;
      pending_q.push_back(it);
   endtask

   task automatic push_marker(input seq_kind_type kind, input logic inv);
      pending_item_type it;
      it.kind = kind;
      it.code = REQ_LOAD;
      it.idx  = '0;
      it.re   = '0;
      it.im   = '0;
      it.inv  = inv;
      pending_q.push_back(it);
   endtask

   // Mode changes only once the block has gone quiet.
   task automatic push_mode(input logic inv);
      push_marker(SEQ_DRAIN, 1'b0);
      push_marker(SEQ_CSR, inv);
   endtask

   // Load every entry of the frame; style 0 random, 1 extremes, 2 small values.
   task automatic fill_frame(input int style);
      logic signed [23:0] re, im;
      for (int i = 0; i < NPTS; i++) begin
         case (style)
            1: begin
               re = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
               im = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            end
            2: begin
               re = 24'($signed($urandom_range(0, 2000)) - 1000);
               im = 24'($signed($urandom_range(0, 2000)) - 1000);
            end
            default: begin
               re = random_sample();
               im = random_sample();
            end
         endcase
         push_request(REQ_LOAD, i, re, im);
      end
   endtask

   // Random mix: mostly reads and loads, rare runs, some unknown codes and pauses.
   task automatic random_mix(input int count, input int runs);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (runs > 0 && pick < 1) begin
            push_request(REQ_RUN, 0, '0, '0);
            runs--;
         end else if (pick < 50) begin
            push_request(REQ_READ, $urandom_range(0, NPTS - 1), random_sample(), random_sample());
         end else if (pick < 94) begin
            push_request(REQ_LOAD, $urandom_range(0, NPTS - 1), random_sample(), random_sample());
         end else if (pick < 97) begin
            push_request(REQ_UNKNOWN, $urandom_range(0, NPTS - 1), random_sample(),
                         random_sample());
         end else begin
            push_marker(SEQ_DRAIN, 1'b0);
         end
      end
      if (runs > 0) push_request(REQ_RUN, 0, '0, '0);
   endtask

   function automatic int random_gap();
      case ($urandom_range(0, 19))
         0:  return $urandom_range(15, 60);
         1, 2, 3, 4, 5: return $urandom_range(1, 4);
         default: return 0;
      endcase
   endfunction

   // Driver: feeds items from the pending queue, honoring busy and csr_ready.
   always @(posedge clock) begin
      if (reset) begin
         start        <= 1'b0;
         csr_valid    <= 1'b0;
         gap_left     = 0;
         settle_count = 0;
      end else begin
         if (start && !busy) begin
            predict_request(pending_q.pop_front());
            gap_left = random_gap();
         end
         if (csr_valid && csr_ready) begin
            inverse_mode = pending_q.pop_front().inv;
            gap_left     = random_gap();
         end
         // Drain markers wait out every result and then the block's tail.
         if (pending_q.size() > 0 && pending_q[0].kind == SEQ_DRAIN) begin
            if (expected_q.size() == 0) settle_count++;
            if (settle_count >= SETTLE) begin
               void'(pending_q.pop_front());
               settle_count = 0;
            end
         end
         if (gap_left > 0 || pending_q.size() == 0 || pending_q[0].kind == SEQ_DRAIN) begin
            if (gap_left > 0) gap_left--;
            start     <= 1'b0;
            csr_valid <= 1'b0;
         end else if (pending_q[0].kind == SEQ_CSR) begin
            start       <= 1'b0;
            csr_valid   <= 1'b1;
            csr_inverse <= pending_q[0].inv;
         end else begin
            start         <= 1'b1;
            csr_valid     <= 1'b0;
            req_type      <= pending_q[0].code;
            req_index     <= pending_q[0].idx;
            req_sample_re <= pending_q[0].re;
            req_sample_im <= pending_q[0].im;
         end
      end
   end

   // Monitor: checks each strobed result against the oldest expectation.
   always @(posedge clock) begin
      bin_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            exp_res = expected_q.pop_front();
            if (rsp_result_kind !== exp_res.kind)
               report_mismatch($sformatf("kind %0b, expected %0b", rsp_result_kind, exp_res.kind));
            if (rsp_out_re !== exp_res.re)
               report_mismatch($sformatf("out_re %0d, expected %0d", rsp_out_re, exp_res.re));
            if (rsp_out_im !== exp_res.im)
               report_mismatch($sformatf("out_im %0d, expected %0d", rsp_out_im, exp_res.im));
         end
      end
   end

   // Watchdog: a run is long, but nothing should stall far beyond it.
   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      start         <= 1'b0;
      req_type      <= REQ_LOAD;
      req_index     <= '0;
      req_sample_re <= '0;
      req_sample_im <= '0;
      csr_valid     <= 1'b0;
      csr_inverse   <= 1'b0;
      reset         <= 1'b1;
      error_count   = 0;
      inverse_mode  = 1'b0;
      for (int i = 0; i < NPTS; i++) begin
         frame_re[i] = 0;
         frame_im[i] = 0;
      end
      build_twiddles();

      // Directed: extremes, reads before any run, unknown request code.
      push_request(REQ_LOAD, 0, 24'sh7FFFFF, 24'sh800000);
      push_request(REQ_LOAD, NPTS - 1, 24'sh800000, 24'sh7FFFFF);
      push_request(REQ_LOAD, 5, 24'sd0, 24'sd0);
      push_request(REQ_LOAD, 1024, 24'sh555555, 24'shAAAAAA);
      push_request(REQ_READ, 0, '0, '0);
      push_request(REQ_READ, NPTS - 1, '0, '0);
      push_request(REQ_UNKNOWN, 7, 24'sh7FFFFF, 24'sh7FFFFF);
      push_request(REQ_READ, 5, '0, '0);
      push_request(REQ_READ, 1024, '0, '0);
      push_request(REQ_LOAD, 0, 24'sh800000, 24'sh7FFFFF);
      push_request(REQ_READ, 0, '0, '0);

      // Forward transform on a full random frame, then a random mix that holds one more run.
      fill_frame(0);
      push_request(REQ_RUN, 0, '0, '0);
      push_request(REQ_READ, 0, '0, '0);
      push_request(REQ_READ, NPTS - 1, '0, '0);
      random_mix(250, 1);
      push_mode(1'b1);

      // Inverse transform over the frame as it stands, every entry already written.
      push_request(REQ_RUN, 0, '0, '0);
      random_mix(200, 1);
      push_mode(1'b0);

      // Forward again with a mix of loads and reads.
      push_request(REQ_RUN, 0, '0, '0);
      random_mix(150, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ radix2_fft_fixed_core.f @@
rtl/r2fft_pkg.sv
rtl/r2fft_ctrl.sv
rtl/r2fft_datapath.sv
rtl/radix2_fft_fixed_core.sv
verif/radix2_fft_fixed_core_tb.sv
